// File: rtl/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg: shared constants for the bounded deque with search
// Opcode and status codes, payload widths.
// ---------------------------------------------------------------------------
package bdq_pkg;

   parameter int OP_W   = 4;
   parameter int DATA_W = 32;
   parameter int STAT_W = 2;

   typedef logic [OP_W-1:0]   opcode_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [DATA_W-1:0] data_type;

   parameter opcode_type OP_PUSH_FRONT = 4'd0;
   parameter opcode_type OP_PUSH_BACK  = 4'd1;
   parameter opcode_type OP_POP_FRONT  = 4'd2;
   parameter opcode_type OP_POP_BACK   = 4'd3;
   parameter opcode_type OP_COUNT      = 4'd4;
   parameter opcode_type OP_CONTAINS   = 4'd5;
   parameter opcode_type OP_MAX        = 4'd6;
   parameter opcode_type OP_MIN        = 4'd7;
   parameter opcode_type OP_LENGTH     = 4'd8;
   parameter opcode_type OP_CLEAR      = 4'd9;

   parameter status_type STAT_OK        = 2'd0;
   parameter status_type STAT_EMPTY     = 2'd1;
   parameter status_type STAT_FULL      = 2'd2;
   parameter status_type STAT_NOT_FOUND = 2'd3;

endpackage

// File: rtl/bdq_ram.sv
// ---------------------------------------------------------------------------
// bdq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bounded_deque_with_search.sv
// ---------------------------------------------------------------------------
// bounded_deque_with_search: bounded double-ended queue of signed words
// Ring of DEPTH entries in a RAM; count, contains, max and min walk the
// occupied entries through one shared compare unit.
// ---------------------------------------------------------------------------
//  channel   | ports                          | transfer
//  ----------+--------------------------------+-------------------------------
//  request   | start, busy, req_*             | start high while busy low
//  response  | rsp_valid, rsp_*               | one cycle with rsp_valid high
//
//  Push, pop, length, clear and any operation on an empty queue: the
//  response appears the cycle after the transfer and busy stays low.
//  Count, contains, max and min on N entries: busy for one RAM read per
//  cycle and the wait on the last registered read; response in the next cycle.
//  Reset clears front index and occupancy; RAM contents need no clearing.
//  The response is never stalled.
// ---------------------------------------------------------------------------
module bounded_deque_with_search #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bdq_pkg::OP_W-1:0]     req_opcode,
   input  logic signed [bdq_pkg::DATA_W-1:0] req_operand_value,
   output logic                         rsp_valid,
   output logic [bdq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [bdq_pkg::DATA_W-1:0] rsp_extreme_value,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_match_count,
   output logic                         rsp_key_present,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_entry_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW:0]      DEPTH_SUM = (AW+1)'(DEPTH);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + AW'(1);
   endfunction

   logic                      state_ff, state_in;
   logic [AW-1:0]             front_ff, front_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   bdq_pkg::opcode_type       op_ff, op_in;
   bdq_pkg::data_type         key_ff, key_in;
   logic [AW-1:0]             scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]          issue_left_ff, issue_left_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      first_ff, first_in;
   bdq_pkg::data_type         acc_ff, acc_in;
   logic [CNT_W-1:0]          match_ff, match_in;
   logic                      present_ff, present_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   bdq_pkg::status_type       rsp_status_ff, rsp_status_in;
   bdq_pkg::data_type         rsp_extreme_ff, rsp_extreme_in;
   logic [CNT_W-1:0]          rsp_match_ff, rsp_match_in;
   logic                      rsp_present_ff, rsp_present_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic                      rd_en;
   bdq_pkg::data_type         rd_data;

   logic                      is_full, is_empty;
   logic [AW-1:0]             front_dec, back_addr;
   logic [AW:0]               back_sum;
   bdq_pkg::data_type         lt_lhs, lt_rhs;
   logic                      cmp_eq, cmp_lt, take;

   assign is_full   = (occ_ff == FULL_CNT);
   assign is_empty  = (occ_ff == '0);
   assign front_dec = (front_ff == '0) ? LAST_ADDR : front_ff - AW'(1);
   // occupancy is below DEPTH on a push, so one subtract wraps the sum
   assign back_sum  = {1'b0, front_ff} + {1'b0, occ_ff[AW-1:0]};
   assign back_addr = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM)
                                              : back_sum[AW-1:0];

   // shared compare unit; swap operands so max takes a strictly larger entry
   assign lt_lhs = (op_ff == bdq_pkg::OP_MAX) ? acc_ff : rd_data;
   assign lt_rhs = (op_ff == bdq_pkg::OP_MAX) ? rd_data : acc_ff;
   assign cmp_eq = (rd_data == key_ff);
   assign cmp_lt = ($signed(lt_lhs) < $signed(lt_rhs));
   assign take   = first_ff || cmp_lt;

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      occ_in         = occ_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      scan_addr_in   = scan_addr_ff;
      issue_left_in  = issue_left_ff;
      rd_vld_in      = 1'b0;
      first_in       = first_ff;
      acc_in         = acc_ff;
      match_in       = match_ff;
      present_in     = present_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_extreme_in = rsp_extreme_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = front_dec;
      rd_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in          = req_opcode;
               key_in         = req_operand_value;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = bdq_pkg::STAT_OK;
               rsp_extreme_in = '0;
               rsp_match_in   = '0;
               rsp_present_in = 1'b0;
               unique case (req_opcode)
                  bdq_pkg::OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = bdq_pkg::STAT_FULL;
                     end else begin
                        front_in = front_dec;
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        occ_in   = occ_ff + CNT_W'(1);
                     end
                  end
                  bdq_pkg::OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = bdq_pkg::STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = back_addr;
                        occ_in  = occ_ff + CNT_W'(1);
                     end
                  end
                  bdq_pkg::OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = bdq_pkg::STAT_EMPTY;
                     end else begin
                        front_in = addr_inc(front_ff);
                        occ_in   = occ_ff - CNT_W'(1);
                     end
                  end
                  bdq_pkg::OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = bdq_pkg::STAT_EMPTY;
                     end else begin
                        occ_in = occ_ff - CNT_W'(1);
                     end
                  end
                  bdq_pkg::OP_COUNT, bdq_pkg::OP_CONTAINS,
                  bdq_pkg::OP_MAX, bdq_pkg::OP_MIN: begin
                     if (is_empty) begin
                        rsp_status_in = (req_opcode == bdq_pkg::OP_CONTAINS)
                                        ? bdq_pkg::STAT_NOT_FOUND : bdq_pkg::STAT_EMPTY;
                     end else begin
                        // hold the response until the walk is done
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_SCAN;
                        scan_addr_in  = front_ff;
                        issue_left_in = occ_ff;
                        first_in      = 1'b1;
                        acc_in        = '0;
                        match_in      = '0;
                        present_in    = 1'b0;
                     end
                  end
                  bdq_pkg::OP_CLEAR: begin
                     front_in = '0;
                     occ_in   = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = occ_in;
            end
         end
         ST_SCAN: begin
            if (issue_left_ff != '0) begin
               rd_en         = 1'b1;
               rd_vld_in     = 1'b1;
               scan_addr_in  = addr_inc(scan_addr_ff);
               issue_left_in = issue_left_ff - CNT_W'(1);
            end
            if (rd_vld_ff) begin
               first_in = 1'b0;
               if (cmp_eq) begin
                  match_in   = match_ff + CNT_W'(1);
                  present_in = 1'b1;
               end
               if (take) begin
                  acc_in = rd_data;
               end
               if (issue_left_ff == '0) begin
                  state_in       = ST_IDLE;
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = bdq_pkg::STAT_OK;
                  rsp_extreme_in = (op_ff == bdq_pkg::OP_MAX || op_ff == bdq_pkg::OP_MIN)
                                   ? acc_in : '0;
                  rsp_match_in   = (op_ff == bdq_pkg::OP_COUNT) ? match_in : '0;
                  rsp_present_in = (op_ff == bdq_pkg::OP_CONTAINS) ? present_in : 1'b0;
                  rsp_count_in   = occ_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      scan_addr_ff   <= scan_addr_in;
      issue_left_ff  <= issue_left_in;
      first_ff       <= first_in;
      acc_ff         <= acc_in;
      match_ff       <= match_in;
      present_ff     <= present_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_extreme_ff <= rsp_extreme_in;
      rsp_match_ff   <= rsp_match_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
   end

   bdq_ram #(
      .WIDTH (bdq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_operand_value),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign busy              = (state_ff == ST_SCAN);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_extreme_value = rsp_extreme_ff;
   assign rsp_match_count   = rsp_match_ff;
   assign rsp_key_present   = rsp_present_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule
